/* rtl/slab_object_allocator_defines.svh */
// Assertion macros used by the slab allocator RTL.
// Expects clk_i and rst_ni in the scope of use.
`ifndef SLAB_OBJECT_ALLOCATOR_DEFINES_SVH
`define SLAB_OBJECT_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define SOA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SOA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/soa_pkg.sv */
// Shared types and constants of the slab object allocator.
// No dependencies.
package soa_pkg;

  localparam int ADDR_W   = 19;  // pool byte offset
  localparam int OSIZE_W  = 16;  // object_size register
  localparam int OALIGN_W = 13;  // object_align register
  localparam int ORDER_W  = 2;   // slab order register
  localparam int SIZE_W   = 17;  // rounded object size, up to 65536
  localparam int ALIGN_W  = 13;  // alignment mask, up to 8191
  localparam int STATUS_W = 2;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

  localparam logic [1:0] REG_SIZE  = 2'd0;
  localparam logic [1:0] REG_ALIGN = 2'd1;
  localparam logic [1:0] REG_ORDER = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0]  size;   // rounded object size
    logic [ALIGN_W-1:0] mask;   // alignment minus one
    logic [ORDER_W-1:0] order;  // raw page order
  } soa_geom_t;

endpackage

/* rtl/soa_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on soa_pkg.
module soa_div #(
  parameter int DVD_W = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DVD_W-1:0]           dividend_i,
  input  logic [soa_pkg::SIZE_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [DVD_W-1:0]           quot_o,
  output logic [soa_pkg::SIZE_W-1:0] rem_o
);
  import soa_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic              run_q, run_d, done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DVD_W-1:0]  quot_q, quot_d;
  logic [SIZE_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [SIZE_W:0]   trial, diff;
  logic              ge;

  assign trial = {rem_q, quot_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (run_q) begin
      rem_d  = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      quot_d = {quot_q[DVD_W-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/soa_cfg.sv */
// APB register file and object geometry of the slab allocator.
// Depends on soa_pkg.
module soa_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [soa_pkg::APB_AW-1:0] paddr,
  input  logic [soa_pkg::APB_DW-1:0] pwdata,
  output logic [soa_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic                       clr_o,
  output soa_pkg::soa_geom_t         geom_o
);
  import soa_pkg::*;

  logic [OSIZE_W-1:0]  size_q;
  logic [OALIGN_W-1:0] align_q;
  logic [ORDER_W-1:0]  order_q;
  logic                wr;
  logic [1:0]          idx;
  logic [OALIGN_W-1:0] al, m;
  logic [SIZE_W-1:0]   sz;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign clr_o  = wr && (idx == REG_SIZE || idx == REG_ALIGN || idx == REG_ORDER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= OSIZE_W'(8);
      align_q <= OALIGN_W'(8);
      order_q <= '0;
    end else if (wr) begin
      case (idx)
        REG_SIZE:  size_q  <= pwdata[OSIZE_W-1:0];
        REG_ALIGN: align_q <= pwdata[OALIGN_W-1:0];
        REG_ORDER: order_q <= pwdata[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SIZE:  prdata = APB_DW'(size_q);
      REG_ALIGN: prdata = APB_DW'(align_q);
      REG_ORDER: prdata = APB_DW'(order_q);
      default:   prdata = '0;
    endcase
  end

  // next power of two as a mask: smear the bits of (align - 1)
  always_comb begin
    al = (align_q < OALIGN_W'(8)) ? OALIGN_W'(8) : align_q;
    m  = (al - OALIGN_W'(1)) | OALIGN_W'(7);
    m  = m | (m >> 1);
    m  = m | (m >> 2);
    m  = m | (m >> 4);
    m  = m | (m >> 8);
    sz = (size_q < OSIZE_W'(8)) ? SIZE_W'(8) : SIZE_W'(size_q);
    geom_o.mask  = m;
    geom_o.size  = (sz + SIZE_W'(m)) & ~SIZE_W'(m);
    geom_o.order = order_q;
  end

endmodule

/* rtl/slab_object_allocator.sv */
// Slab object allocator: sequencer, slab tables and free-list memory.
// Depends on soa_pkg, soa_cfg, soa_div and slab_object_allocator_defines.svh.
//
// One request at a time: a request is taken when start is high and busy is low,
// and its single result shows on address_res_o/status_o for exactly one cycle
// with done_o high. The receiver cannot stall; it must take the result then.
// Steps per request (DVD_W = divider width, about log2 of the slab span plus
// one, at least 14; one quotient bit per cycle in the shared divider):
//   alloc from an existing slab: pages scanned (one per cycle), then the
//     slot read, its address formed and the head popped.
//   alloc taking a new slab: pages scanned, one divide for the objects in the
//     slab, then the slab's free list chained one slot per cycle.
//   free: two divides (slot index, slab capacity), then the slot pushed.
// A write to the size, align or order register empties the pool; write only while busy is low.
`include "slab_object_allocator_defines.svh"

module slab_object_allocator #(
  parameter int MAX_PAGES  = 16,
  parameter int MAX_OBJS   = 512,
  parameter int PAGE_BYTES = 4096,
  parameter int MAX_ORDER  = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [soa_pkg::APB_AW-1:0]   paddr,
  input  logic [soa_pkg::APB_DW-1:0]   pwdata,
  output logic [soa_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode_i,
  input  logic [soa_pkg::ADDR_W-1:0]   address_i,
  output logic                         done_o,
  output logic [soa_pkg::ADDR_W-1:0]   address_res_o,
  output logic [soa_pkg::STATUS_W-1:0] status_o
);
  import soa_pkg::*;

  localparam int PG_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PU_W     = $clog2(MAX_PAGES + 1);
  localparam int SLOT_W   = (MAX_OBJS > 1) ? $clog2(MAX_OBJS) : 1;
  localparam int OBJ_W    = $clog2(MAX_OBJS + 1);
  localparam int PB_SH    = $clog2(PAGE_BYTES);
  localparam int SPAN_W   = PB_SH + MAX_ORDER + 1;
  localparam int DVD_W    = (SPAN_W > 14) ? SPAN_W : 14;
  localparam int SH_W     = $clog2(PB_SH + MAX_ORDER + 1);
  localparam int NS_DEPTH = MAX_PAGES * MAX_OBJS;
  localparam int NS_AW    = (NS_DEPTH > 1) ? $clog2(NS_DEPTH) : 1;
  localparam int BASE_W   = PG_W + SPAN_W + ALIGN_W;
  localparam int WX       = (DVD_W > ADDR_W) ? DVD_W : ADDR_W;
  localparam int FIT_W    = PU_W + SPAN_W + ADDR_W;
  localparam int MUL_W    = SLOT_W + SIZE_W;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_RDPG  = 4'd2;
  localparam logic [3:0] S_ANS   = 4'd3;
  localparam logic [3:0] S_AWR   = 4'd4;
  localparam logic [3:0] S_NEW   = 4'd5;
  localparam logic [3:0] S_NLEAD = 4'd6;
  localparam logic [3:0] S_NDIV  = 4'd7;
  localparam logic [3:0] S_CHAIN = 4'd8;
  localparam logic [3:0] S_FCHK  = 4'd9;
  localparam logic [3:0] S_FLEAD = 4'd10;
  localparam logic [3:0] S_FDIV1 = 4'd11;
  localparam logic [3:0] S_FDIV2 = 4'd12;
  localparam logic [3:0] S_FWR   = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  soa_geom_t geom;
  logic      cfg_clr;

  soa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .clr_o   (cfg_clr),
    .geom_o  (geom)
  );

  // shared divider
  logic              dv_start, dv_done;
  logic [DVD_W-1:0]  dv_dvd, dv_quot;
  logic [SIZE_W-1:0] dv_rem;

  soa_div #(.DVD_W(DVD_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_dvd),
    .divisor_i  (geom.size),
    .done_o     (dv_done),
    .quot_o     (dv_quot),
    .rem_o      (dv_rem)
  );

  // state
  logic [3:0]          state_q, state_d;
  logic                op_q, op_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [PU_W-1:0]     used_q, used_d;
  logic [PG_W-1:0]     idx_q, idx_d, pg_q, pg_d;
  logic [SLOT_W-1:0]   k_q, k_d;
  logic [DVD_W-1:0]    kq_q, kq_d;
  logic [OBJ_W-1:0]    objs_q, objs_d;
  logic [ADDR_W-1:0]   prod_q, prod_d, res_q, res_d;
  logic [STATUS_W-1:0] st_q, st_d;
  logic [MAX_PAGES-1:0] nonempty_q, nonempty_d;

  // slab tables and free-list links
  logic [SLOT_W-1:0] pg_head_mem [MAX_PAGES];
  logic [OBJ_W-1:0]  pg_cnt_mem  [MAX_PAGES];
  logic [SLOT_W-1:0] ns_mem      [NS_DEPTH];
  logic [SLOT_W-1:0] head_rd_q, ns_rd_q;
  logic [OBJ_W-1:0]  cnt_rd_q;
  logic              pg_we, ns_we;
  logic [SLOT_W-1:0] pg_wh, ns_wd, ns_slot;
  logic [OBJ_W-1:0]  pg_wc;
  logic [NS_AW-1:0]  ns_addr;

  // geometry of the current slab
  logic [ORDER_W-1:0] ord;
  logic [SH_W-1:0]    sh;
  logic [BASE_W-1:0]  base;
  logic [ALIGN_W-1:0] lead;
  logic [DVD_W-1:0]   span, lead_x, cap_dvd, off;
  logic [WX-1:0]      span_x;
  logic [ADDR_W-1:0]  p_full, base_a, lead_a;
  logic [FIT_W-1:0]   fit_end;
  logic [OBJ_W-1:0]   objs_clip, k_inc;

  assign ord    = (32'(geom.order) > MAX_ORDER) ? ORDER_W'(MAX_ORDER) : geom.order;
  assign sh     = SH_W'(PB_SH) + SH_W'(ord);
  assign span   = DVD_W'(1) << sh;
  assign base   = BASE_W'(pg_q) << sh;
  assign lead   = (ALIGN_W'(0) - base[ALIGN_W-1:0]) & geom.mask;
  assign lead_x = DVD_W'(lead);
  assign cap_dvd = span - lead_x;
  assign span_x = WX'(1) << sh;
  assign off    = DVD_W'(WX'(addr_q) & (span_x - WX'(1)));
  assign p_full = addr_q >> sh;
  assign base_a = base[ADDR_W-1:0];
  assign lead_a = ADDR_W'(lead);
  assign fit_end = (FIT_W'(used_q) + FIT_W'(1)) << sh;
  assign objs_clip = (dv_quot > DVD_W'(MAX_OBJS)) ? OBJ_W'(MAX_OBJS)
                                                   : dv_quot[OBJ_W-1:0];
  assign k_inc  = OBJ_W'(k_q) + OBJ_W'(1);

  always_comb begin
    case (state_q)
      S_ANS:   ns_slot = head_rd_q;
      S_FWR:   ns_slot = kq_q[SLOT_W-1:0];
      default: ns_slot = k_q;
    endcase
  end
  assign ns_addr = NS_AW'(NS_AW'(pg_q) * NS_AW'(MAX_OBJS)) + NS_AW'(ns_slot);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    addr_d     = addr_q;
    used_d     = used_q;
    idx_d      = idx_q;
    pg_d       = pg_q;
    k_d        = k_q;
    kq_d       = kq_q;
    objs_d     = objs_q;
    prod_d     = prod_q;
    res_d      = res_q;
    st_d       = st_q;
    nonempty_d = nonempty_q;
    dv_start   = 1'b0;
    dv_dvd     = cap_dvd;
    pg_we      = 1'b0;
    pg_wh      = '0;
    pg_wc      = '0;
    ns_we      = 1'b0;
    ns_wd      = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d   = opcode_i;
          addr_d = address_i;
          res_d  = '0;
          if (opcode_i == OP_FREE) begin
            state_d = S_FCHK;
          end else if (used_q == '0) begin
            state_d = S_NEW;
          end else begin
            idx_d   = PG_W'(used_q - PU_W'(1));
            state_d = S_SCAN;
          end
        end
      end
      // newest slab first, one per cycle
      S_SCAN: begin
        if (nonempty_q[idx_q]) begin
          pg_d    = idx_q;
          state_d = S_RDPG;
        end else if (idx_q == '0) begin
          state_d = S_NEW;
        end else begin
          idx_d = idx_q - PG_W'(1);
        end
      end
      S_RDPG: state_d = S_ANS;
      S_ANS: begin
        prod_d  = ADDR_W'(MUL_W'(head_rd_q) * MUL_W'(geom.size));
        state_d = S_AWR;
      end
      // pop: head moves to its link
      S_AWR: begin
        pg_we   = 1'b1;
        pg_wh   = ns_rd_q;
        pg_wc   = cnt_rd_q - OBJ_W'(1);
        nonempty_d[pg_q] = (cnt_rd_q != OBJ_W'(1));
        res_d   = base_a + lead_a + prod_q;
        st_d    = ST_OK;
        state_d = S_OUT;
      end
      S_NEW: begin
        pg_d = PG_W'(used_q);
        if (32'(used_q) < MAX_PAGES && fit_end <= (FIT_W'(1) << ADDR_W)) begin
          state_d = S_NLEAD;
        end else begin
          st_d    = ST_NOMEM;
          state_d = S_OUT;
        end
      end
      S_NLEAD: begin
        if (span > lead_x) begin
          dv_start = 1'b1;
          state_d  = S_NDIV;
        end else begin
          st_d    = ST_NOMEM;
          state_d = S_OUT;
        end
      end
      S_NDIV: begin
        if (dv_done) begin
          objs_d = objs_clip;
          k_d    = '0;
          if (objs_clip == '0) begin
            st_d    = ST_NOMEM;
            state_d = S_OUT;
          end else begin
            state_d = S_CHAIN;
          end
        end
      end
      // link slot k to k+1, last slot to 0; then pop slot 0
      S_CHAIN: begin
        ns_we = 1'b1;
        ns_wd = (k_inc < objs_q) ? SLOT_W'(k_inc) : '0;
        k_d   = k_q + SLOT_W'(1);
        if (k_inc == objs_q) begin
          pg_we   = 1'b1;
          pg_wh   = (objs_q > OBJ_W'(1)) ? SLOT_W'(1) : '0;
          pg_wc   = objs_q - OBJ_W'(1);
          nonempty_d[pg_q] = (objs_q > OBJ_W'(1));
          used_d  = used_q + PU_W'(1);
          res_d   = base_a + lead_a;
          st_d    = ST_OK;
          state_d = S_OUT;
        end
      end
      S_FCHK: begin
        pg_d = p_full[PG_W-1:0];
        if (p_full < ADDR_W'(used_q) && (addr_q[ALIGN_W-1:0] & geom.mask) == '0) begin
          state_d = S_FLEAD;
        end else begin
          st_d    = ST_BADFREE;
          state_d = S_OUT;
        end
      end
      S_FLEAD: begin
        if (off >= lead_x) begin
          dv_dvd   = off - lead_x;
          dv_start = 1'b1;
          state_d  = S_FDIV1;
        end else begin
          st_d    = ST_BADFREE;
          state_d = S_OUT;
        end
      end
      S_FDIV1: begin
        if (dv_done) begin
          kq_d = dv_quot;
          if (dv_rem != '0) begin
            st_d    = ST_BADFREE;
            state_d = S_OUT;
          end else begin
            dv_start = 1'b1;
            state_d  = S_FDIV2;
          end
        end
      end
      // slot must exist and slab must not be all free
      S_FDIV2: begin
        if (dv_done) begin
          if (kq_q < DVD_W'(objs_clip) && cnt_rd_q < objs_clip) begin
            state_d = S_FWR;
          end else begin
            st_d    = ST_BADFREE;
            state_d = S_OUT;
          end
        end
      end
      S_FWR: begin
        ns_we   = 1'b1;
        ns_wd   = head_rd_q;
        pg_we   = 1'b1;
        pg_wh   = kq_q[SLOT_W-1:0];
        pg_wc   = cnt_rd_q + OBJ_W'(1);
        nonempty_d[pg_q] = 1'b1;
        st_d    = ST_OK;
        state_d = S_OUT;
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (cfg_clr) begin
      used_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    addr_q     <= addr_d;
    idx_q      <= idx_d;
    pg_q       <= pg_d;
    k_q        <= k_d;
    kq_q       <= kq_d;
    objs_q     <= objs_d;
    prod_q     <= prod_d;
    res_q      <= res_d;
    st_q       <= st_d;
    nonempty_q <= nonempty_d;
  end

  always_ff @(posedge clk_i) begin
    if (pg_we) begin
      pg_head_mem[pg_q] <= pg_wh;
      pg_cnt_mem[pg_q]  <= pg_wc;
    end
    head_rd_q <= pg_head_mem[pg_q];
    cnt_rd_q  <= pg_cnt_mem[pg_q];
  end

  always_ff @(posedge clk_i) begin
    if (ns_we) begin
      ns_mem[ns_addr] <= ns_wd;
    end
    ns_rd_q <= ns_mem[ns_addr];
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = (state_q == S_OUT);
  assign address_res_o = (op_q == OP_ALLOC && st_q == ST_OK) ? res_q : '0;
  assign status_o      = st_q;

  `SOA_ASSERT_IMP(a_done_busy, done_o, busy, "result strobe outside a request")
  `SOA_ASSERT_NXT(a_take_busy, start && !busy, busy, "request taken but not busy")
  `SOA_ASSERT_NXT(a_done_idle, done_o, !busy, "not idle after result")
  `SOA_ASSERT_IMP(a_used_max, 1'b1, 32'(used_q) <= MAX_PAGES, "slab count overflow")
  `SOA_ASSERT_IMP(a_fail_zero, done_o && status_o != ST_OK, address_res_o == '0,
                  "failed request returned an address")

endmodule

/* verif/tb_top.sv */
// Testbench for slab_object_allocator: directed and random alloc/free requests,
// checked against an in-bench model of the slab free lists. Depends on soa_pkg and slab_object_allocator.
module tb_top;
  import soa_pkg::*;

  // Expected-result store and slab model. Pages, free lists and geometry are
  // kept here so each accepted request yields one expected (address, status).
  class slab_scoreboard;
    int unsigned cfg_size, cfg_align, cfg_order;
    int unsigned pages_used;
    int unsigned link[16][512];
    int unsigned head[16];
    int unsigned free_cnt[16];
    logic [ADDR_W-1:0]   exp_addr[$];
    logic [STATUS_W-1:0] exp_status[$];
    int unsigned fails;
    // shadow of handed-out objects, used by the stimulus to build good frees
    logic [ADDR_W-1:0] live[$];
    int unsigned g_size, g_align, g_span;

    function new();
      cfg_size = 8; cfg_align = 8; cfg_order = 0;
      pages_used = 0; fails = 0;
    endfunction

    function void set_reg(int unsigned idx, int unsigned val);
      case (idx)
        REG_SIZE:  cfg_size  = val & 16'hFFFF;
        REG_ALIGN: cfg_align = val & 13'h1FFF;
        default:   cfg_order = val & 2'h3;
      endcase
      pages_used = 0;
      live.delete();
    endfunction

    function void calc_geom();
      int unsigned sz, al;
      sz = (cfg_size < 8) ? 8 : cfg_size;
      al = (cfg_align < 8) ? 8 : cfg_align;
      g_align = 8;
      while (g_align < al) g_align <<= 1;
      g_size = (sz + g_align - 1) / g_align * g_align;
      g_span = 4096 << cfg_order;
    endfunction

    function int unsigned lead_of(int unsigned p);
      int unsigned st;
      st = p * g_span;
      return (st + g_align - 1) / g_align * g_align - st;
    endfunction

    function int unsigned objs_of(int unsigned p);
      int unsigned ld, n;
      ld = lead_of(p);
      if (g_span <= ld) return 0;
      n = (g_span - ld) / g_size;
      return (n > 512) ? 512 : n;
    endfunction

    function int unsigned take(int unsigned p);
      int unsigned k;
      k = head[p];
      head[p] = link[p][k];
      free_cnt[p]--;
      return p * g_span + lead_of(p) + k * g_size;
    endfunction

    // note an accepted request and queue its expected result
    function void note_request(logic op, logic [ADDR_W-1:0] a);
      int unsigned res, p, off, k, n;
      logic [STATUS_W-1:0] st;
      bit got;
      res = 0; st = ST_OK; got = 0;
      calc_geom();
      if (op == OP_ALLOC) begin
        for (int i = int'(pages_used) - 1; i >= 0 && !got; i--) begin
          if (free_cnt[i] > 0) begin
            res = take(i);
            got = 1;
          end
        end
        if (!got) begin
          p = pages_used;
          st = ST_NOMEM;
          if (p < 16 && (p + 1) * g_span <= 524288) begin
            n = objs_of(p);
            if (n > 0) begin
              for (int j = 0; j < n; j++) link[p][j] = (j + 1 < n) ? j + 1 : 0;
              head[p] = 0;
              free_cnt[p] = n;
              pages_used = p + 1;
              res = take(p);
              st = ST_OK;
            end
          end
        end
        if (st == ST_OK) live.push_back(ADDR_W'(res));
      end else begin
        p = a / g_span;
        st = ST_BADFREE;
        if (p < pages_used && a % g_align == 0) begin
          off = a - p * g_span;
          if (off >= lead_of(p) && (off - lead_of(p)) % g_size == 0) begin
            k = (off - lead_of(p)) / g_size;
            if (k < objs_of(p) && free_cnt[p] < objs_of(p)) begin
              link[p][k] = head[p];
              head[p] = k;
              free_cnt[p]++;
              st = ST_OK;
              foreach (live[i]) if (live[i] == a) begin
                live.delete(i);
                break;
              end
            end
          end
        end
      end
      exp_addr.push_back(ADDR_W'(res));
      exp_status.push_back(st);
    endfunction

    function void check_result(logic [ADDR_W-1:0] a, logic [STATUS_W-1:0] s);
      logic [ADDR_W-1:0] ea;
      logic [STATUS_W-1:0] es;
      if (exp_addr.size() == 0) begin
        $error("unexpected result: address_res %0h status %0d", a, s);
        fails++;
        return;
      end
      ea = exp_addr.pop_front();
      es = exp_status.pop_front();
      if (a !== ea) begin
        $error("address_res mismatch: expected %0h actual %0h", ea, a);
        fails++;
      end
      if (s !== es) begin
        $error("status mismatch: expected %0d actual %0d", es, s);
        fails++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic opcode_i = OP_ALLOC;
  logic [ADDR_W-1:0] address_i = '0;
  logic done_o;
  logic [ADDR_W-1:0] address_res_o;
  logic [STATUS_W-1:0] status_o;

  slab_scoreboard sb = new();

  always #1 clk_i = ~clk_i;

  slab_object_allocator uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .opcode_i, .address_i, .done_o, .address_res_o, .status_o
  );

  // result monitor: done_o is a one-cycle strobe, sampled at the edge
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(address_res_o, status_o);
  end

  // stop requesting, wait until all expected results are in, then settle
  task automatic drain();
    start <= 1'b0;
    while (sb.exp_addr.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, int unsigned val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << 2;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_geom(int unsigned sz, int unsigned al, int unsigned ord);
    reg_write(REG_SIZE, sz);
    reg_write(REG_ALIGN, al);
    reg_write(REG_ORDER, ord);
  endtask

  // issue one request; gap drawn per request, sometimes none at all.
  // start stays high after acceptance when the next request has no gap,
  // and the block takes it as soon as it is idle again.
  task automatic send(logic op, logic [ADDR_W-1:0] a, bit idle_ok);
    int unsigned gap;
    gap = idle_ok ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    opcode_i  <= op;
    address_i <= a;
    do @(posedge clk_i); while (busy);
    sb.note_request(op, a);
  endtask

  // a free of a live object, or a noisy address now and then
  task automatic send_free(bit idle_ok);
    logic [ADDR_W-1:0] a;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (sb.live.size() > 0 && r < 7)
      a = sb.live[$urandom_range(0, sb.live.size() - 1)];
    else if (sb.live.size() > 0 && r == 7)
      a = sb.live[$urandom_range(0, sb.live.size() - 1)] + ADDR_W'(8); // off a boundary
    else
      a = ADDR_W'($urandom_range(0, 524287));
    send(OP_FREE, a, idle_ok);
  endtask

  initial begin
    int unsigned phase_items;
    bit idle_ok;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset geometry, address extremes, double free, bad frees
    send(OP_FREE, '0, 0);                   // free with no slab
    send(OP_ALLOC, 19'h7FFFF, 0);           // address ignored on alloc
    send(OP_ALLOC, '0, 0);
    send(OP_FREE, 19'd8, 0);
    send(OP_FREE, 19'd8, 0);                // double free
    send(OP_FREE, 19'd3, 0);                // misaligned
    send(OP_FREE, 19'h7FFFF, 0);            // beyond slabs in use
    send(OP_FREE, 19'h40000, 0);
    // zero size and alignment fall back to the minimum
    set_geom(0, 0, 0);
    send(OP_ALLOC, '0, 0);
    send(OP_ALLOC, '0, 0);
    // object bigger than a slab: out of memory
    set_geom(16'hFFFF, 13'h1FFF, 0);
    send(OP_ALLOC, '0, 0);
    // largest slabs, large objects: two objects per slab
    set_geom(16384, 4096, 3);
    for (int i = 0; i < 18; i++) send(OP_ALLOC, '0, 1);
    send(OP_FREE, 19'd16384, 0);
    send(OP_FREE, 19'd16384, 0);            // full slab double free
    send(OP_ALLOC, '0, 0);

    // random phases, each with its own geometry
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_geom(8, 8, 0);
        1: set_geom(16'hFFFF, 1, 3);
        2: set_geom(1, 4096, 0);
        3: set_geom(2048, 8, 0);
        default: set_geom($urandom_range(1, 3000), $urandom_range(1, 600),
                          $urandom_range(0, 3));
      endcase
      phase_items = 50;
      for (int n = 0; n < phase_items; n++) begin
        idle_ok = (n % 20) >= 6;        // stretches with no gaps
        if ($urandom_range(0, 9) < 6)
          send(OP_ALLOC, ADDR_W'($urandom_range(0, 524287)), idle_ok);
        else send_free(idle_ok);
        if (n == 25) drain();           // sender waits for all results
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.fails == 0 && sb.exp_addr.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
